// ===== hw/rtl/particle_euler_step_2d_defines.svh =====
// Assertion macros shared by the particle integrator RTL.
`ifndef PARTICLE_EULER_STEP_2D_DEFINES_SVH
`define PARTICLE_EULER_STEP_2D_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PES2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PES2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pes2d_pkg.sv =====
// Constants, codes and saturation helpers for the particle integrator.
`timescale 1ns / 1ps

package pes2d_pkg;

    // Word kinds
    localparam logic [1:0] KIND_FORCE  = 2'd0;
    localparam logic [1:0] KIND_SPRING = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MASS     = 3'd0;
    localparam logic [2:0] REG_RADIUS   = 3'd1;
    localparam logic [2:0] REG_FRICTION = 3'd2;
    localparam logic [2:0] REG_DT       = 3'd3;
    localparam logic [2:0] REG_GRAVITY  = 3'd4;
    localparam logic [2:0] REG_USE_FRIC = 3'd5;
    localparam logic [2:0] REG_MAXSPEED = 3'd6;

    // Reset values
    localparam logic [30:0] MASS_RST     = 31'd65536;
    localparam logic [18:0] RADIUS_RST   = 19'd32768;
    localparam logic [16:0] DT_RST       = 17'd1092;
    localparam logic [30:0] MAXSPEED_RST = 31'd196608;
    localparam logic signed [31:0] POS_X_RST = 32'sd524288;
    localparam logic signed [31:0] POS_Y_RST = 32'sd589824;

    // Physics constants, Q16.16
    localparam logic signed [31:0] GRAVITY_Y   = -32'sd6423;
    localparam logic [31:0]        WALL_OFFSET = 32'd131;
    localparam logic [31:0]        BOX_W_Q     = 32'd1048576;
    localparam logic [31:0]        BOX_H_Q     = 32'd589824;

    // Iteration counts of the shared divider and root unit
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    // Saturate a wide signed value to signed 32
    function automatic logic signed [31:0] f_sat32(input logic signed [65:0] x);
        logic signed [31:0] res;
        if (x > 66'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // Saturating signed 32-bit add
    function automatic logic signed [31:0] f_add_sat(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [65:0] s;
        s = $signed({{34{a[31]}}, a}) + $signed({{34{b[31]}}, b});
        return f_sat32(s);
    endfunction

endpackage

// ===== hw/rtl/particle_euler_step_2d.sv =====
// One word in flight at a time; the input stalls until the sequencer is idle.
// The divider is bit-serial and the square root takes two radicand bits a cycle;
// both are shared under one sequencer.
// Reset (synchronous, active low) restores position 8.0/9.0, zero velocity and
// acceleration, and the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "particle_euler_step_2d_defines.svh"

module particle_euler_step_2d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_force_x,
    input  logic signed [31:0] i_force_y,
    input  logic signed [31:0] i_anchor_x,
    input  logic signed [31:0] i_anchor_y,
    input  logic signed [31:0] i_stiffness,
    input  logic [30:0]        i_rest_length,
    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [5:0] {
        S_IDLE, S_DIV, S_SQRT, S_GRAV,
        S_FR_M1, S_FR_M2, S_FR_M3, S_FR_NX, S_FR_DX, S_FR_NY, S_FR_DY, S_FR_FY,
        S_SP_D, S_SP_M1, S_SP_M2, S_SP_M3, S_SP_K, S_SP_KX, S_SP_NX, S_SP_DX,
        S_SP_NY, S_SP_DY, S_SP_TY, S_SP_DAMP,
        S_FD_X, S_FD_AX, S_FD_Y, S_FD_AY,
        S_VX, S_VX2, S_VY2, S_PX, S_PX2, S_PY2,
        S_WR, S_WR2, S_WL, S_WL2, S_WT, S_WT2, S_WB, S_WB2, S_OUT
    } t_state;

    t_state r_state, r_ret;

    // configuration
    logic [30:0] r_mass, r_fric, r_maxspd;
    logic [18:0] r_radius;
    logic [16:0] r_dt;
    logic        r_use_grav, r_use_fric;

    // particle state
    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_acc_x, r_acc_y;

    // latched word and working values
    logic [1:0]         r_kind;
    logic signed [31:0] r_ax, r_ay, r_k, r_dx, r_dy, r_kx;
    logic [30:0]        r_rest;
    logic signed [63:0] r_fx, r_fy;
    logic signed [65:0] r_prod;
    logic [63:0]        r_sum;

    // divider
    logic [63:0] r_dvd, r_quo;
    logic [31:0] r_dvs, r_rem;
    logic        r_neg;
    logic [6:0]  r_cnt;

    // square root
    logic [63:0] r_rad;
    logic [31:0] r_root;
    logic [33:0] r_srem;

    // output register
    logic               r_ovalid;
    logic signed [31:0] r_out_x, r_out_y;

    // shared multiplier operands
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [31:0] w_mulq;

    // spring extension, dist - rest
    logic signed [31:0] w_e;

    always_comb begin
        case (r_state)
            S_FR_M1: begin w_ma = {r_vel_x[31], r_vel_x}; w_mb = {r_vel_x[31], r_vel_x}; end
            S_FR_M2: begin w_ma = {r_vel_y[31], r_vel_y}; w_mb = {r_vel_y[31], r_vel_y}; end
            S_FR_NX: begin w_ma = {r_vel_x[31], r_vel_x}; w_mb = {2'b0, r_fric}; end
            S_FR_NY: begin w_ma = {r_vel_y[31], r_vel_y}; w_mb = {2'b0, r_fric}; end
            S_SP_M1: begin w_ma = {r_dx[31], r_dx}; w_mb = {r_dx[31], r_dx}; end
            S_SP_M2: begin w_ma = {r_dy[31], r_dy}; w_mb = {r_dy[31], r_dy}; end
            S_SP_K:  begin w_ma = {r_k[31], r_k}; w_mb = {w_e[31], w_e}; end
            S_SP_NX: begin w_ma = {r_kx[31], r_kx}; w_mb = {r_dx[31], r_dx}; end
            S_SP_NY: begin w_ma = {r_kx[31], r_kx}; w_mb = {r_dy[31], r_dy}; end
            S_VX:    begin w_ma = {r_acc_x[31], r_acc_x}; w_mb = {16'b0, r_dt}; end
            S_VX2:   begin w_ma = {r_acc_y[31], r_acc_y}; w_mb = {16'b0, r_dt}; end
            S_PX, S_WR, S_WL: begin
                w_ma = {r_vel_x[31], r_vel_x}; w_mb = {16'b0, r_dt};
            end
            S_PX2, S_WT, S_WB: begin
                w_ma = {r_vel_y[31], r_vel_y}; w_mb = {16'b0, r_dt};
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_mulq = pes2d_pkg::f_sat32(r_prod >>> 16);

    assign w_e = pes2d_pkg::f_sat32($signed({34'b0, r_root}) - $signed({35'b0, r_rest}));

    // divider operand select and one restoring step
    logic signed [63:0] w_dnum, w_quo;
    logic [63:0]        w_dabs;
    logic [31:0]        w_dden, w_mass1;
    logic [32:0]        w_rsh, w_rsub;
    logic               w_dge;

    assign w_mass1 = (r_mass == 31'd0) ? 32'd1 : {1'b0, r_mass};

    always_comb begin
        case (r_state)
            S_FD_X:  begin w_dnum = {r_fx[47:0], 16'b0}; w_dden = w_mass1; end
            S_FD_Y:  begin w_dnum = {r_fy[47:0], 16'b0}; w_dden = w_mass1; end
            default: begin w_dnum = -$signed(r_prod[63:0]); w_dden = r_root; end
        endcase
    end

    assign w_dabs = w_dnum[63] ? 64'(-w_dnum) : 64'(w_dnum);
    assign w_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign w_rsh  = {r_rem, r_dvd[63]};
    assign w_dge  = w_rsh >= {1'b0, r_dvs};
    assign w_rsub = w_rsh - {1'b0, r_dvs};

    // root step, two radicand bits a cycle
    logic [35:0] w_ssh, w_trial, w_ssub;
    logic        w_sge;
    assign w_ssh   = {r_srem, r_rad[63:62]};
    assign w_trial = {2'b0, r_root, 2'b01};
    assign w_sge   = w_ssh >= w_trial;
    assign w_ssub  = w_ssh - w_trial;

    // velocity update with clamp
    logic signed [31:0] w_vnew, w_vcl;
    logic signed [32:0] w_vs, w_vmax;
    assign w_vnew = pes2d_pkg::f_add_sat((r_state == S_VX2) ? r_vel_x : r_vel_y, w_mulq);
    assign w_vs   = {w_vnew[31], w_vnew};
    assign w_vmax = {2'b0, r_maxspd};
    always_comb begin
        if (w_vs > w_vmax) begin
            w_vcl = {1'b0, r_maxspd};
        end else if (w_vs < -w_vmax) begin
            w_vcl = 32'(-w_vmax);
        end else begin
            w_vcl = w_vnew;
        end
    end

    // spring damping, floor(3v/4)
    logic signed [33:0] w_dmp_x, w_dmp_y;
    assign w_dmp_x = ($signed({{2{r_vel_x[31]}}, r_vel_x}) +
                      $signed({r_vel_x[31], r_vel_x, 1'b0})) >>> 2;
    assign w_dmp_y = ($signed({{2{r_vel_y[31]}}, r_vel_y}) +
                      $signed({r_vel_y[31], r_vel_y, 1'b0})) >>> 2;

    // wall tests and bounce values
    logic signed [34:0] w_rad35, w_t35, w_px35, w_py35;
    logic               w_hit_r, w_hit_l, w_hit_t, w_hit_b;
    logic signed [32:0] w_nvx, w_nvy;
    assign w_rad35 = {16'b0, r_radius};
    assign w_t35   = {{3{w_mulq[31]}}, w_mulq};
    assign w_px35  = {{3{r_pos_x[31]}}, r_pos_x};
    assign w_py35  = {{3{r_pos_y[31]}}, r_pos_y};
    assign w_hit_r = (w_px35 + w_rad35 + w_t35) > $signed({3'b0, pes2d_pkg::BOX_W_Q});
    assign w_hit_l = (w_px35 - w_rad35 + w_t35) < 35'sd0;
    assign w_hit_t = (w_py35 + w_rad35 + w_t35) > $signed({3'b0, pes2d_pkg::BOX_H_Q});
    assign w_hit_b = (w_py35 - w_rad35 + w_t35) < 35'sd0;
    assign w_nvx   = (-$signed({r_vel_x[31], r_vel_x})) >>> 1;
    assign w_nvy   = (-$signed({r_vel_y[31], r_vel_y})) >>> 1;

    // register read-back
    always_comb begin
        unique case (paddr[4:2])
            pes2d_pkg::REG_MASS:     prdata = {1'b0, r_mass};
            pes2d_pkg::REG_RADIUS:   prdata = {13'b0, r_radius};
            pes2d_pkg::REG_FRICTION: prdata = {1'b0, r_fric};
            pes2d_pkg::REG_DT:       prdata = {15'b0, r_dt};
            pes2d_pkg::REG_GRAVITY:  prdata = {31'b0, r_use_grav};
            pes2d_pkg::REG_USE_FRIC: prdata = {31'b0, r_use_fric};
            pes2d_pkg::REG_MAXSPEED: prdata = {1'b0, r_maxspd};
            default:                 prdata = 32'd0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_pos_x = r_out_x;
    assign o_out_pos_y = r_out_y;

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_ovalid   <= 1'b0;
            r_cnt      <= '0;
            r_mass     <= pes2d_pkg::MASS_RST;
            r_radius   <= pes2d_pkg::RADIUS_RST;
            r_fric     <= '0;
            r_dt       <= pes2d_pkg::DT_RST;
            r_use_grav <= 1'b0;
            r_use_fric <= 1'b0;
            r_maxspd   <= pes2d_pkg::MAXSPEED_RST;
            r_pos_x    <= pes2d_pkg::POS_X_RST;
            r_pos_y    <= pes2d_pkg::POS_Y_RST;
            r_vel_x    <= '0;
            r_vel_y    <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                unique case (paddr[4:2])
                    pes2d_pkg::REG_MASS:     r_mass     <= pwdata[30:0];
                    pes2d_pkg::REG_RADIUS:   r_radius   <= pwdata[18:0];
                    pes2d_pkg::REG_FRICTION: r_fric     <= pwdata[30:0];
                    pes2d_pkg::REG_DT:       r_dt       <= pwdata[16:0];
                    pes2d_pkg::REG_GRAVITY:  r_use_grav <= pwdata[0];
                    pes2d_pkg::REG_USE_FRIC: r_use_fric <= pwdata[0];
                    pes2d_pkg::REG_MAXSPEED: r_maxspd   <= pwdata[30:0];
                    default: ;
                endcase
            end

            // drop the result word once taken, unless a new one loads now
            if (r_ovalid && !i_out_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            r_prod <= w_prod;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind <= i_kind;
                        r_ax   <= i_anchor_x;
                        r_ay   <= i_anchor_y;
                        r_k    <= i_stiffness;
                        r_rest <= i_rest_length;
                        r_fx   <= {{32{i_force_x[31]}}, i_force_x};
                        r_fy   <= {{32{i_force_y[31]}}, i_force_y};
                        case (i_kind)
                            pes2d_pkg::KIND_FORCE:  r_state <= S_FD_X;
                            pes2d_pkg::KIND_SPRING: r_state <= S_SP_D;
                            pes2d_pkg::KIND_TICK:   r_state <= S_GRAV;
                            default:                r_state <= S_IDLE;
                        endcase
                    end
                end

                // bit-serial divide, one quotient bit a cycle
                S_DIV: begin
                    r_rem <= w_dge ? w_rsub[31:0] : w_rsh[31:0];
                    r_quo <= {r_quo[62:0], w_dge};
                    r_dvd <= {r_dvd[62:0], 1'b0};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_ret;
                    end
                end

                // integer root, one root bit a cycle
                S_SQRT: begin
                    r_srem <= w_sge ? w_ssub[33:0] : w_ssh[33:0];
                    r_root <= {r_root[30:0], w_sge};
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_ret;
                    end
                end

                S_GRAV: begin
                    if (r_use_grav) begin
                        r_acc_y <= pes2d_pkg::f_add_sat(r_acc_y, pes2d_pkg::GRAVITY_Y);
                    end
                    r_state <= r_use_fric ? S_FR_M1 : S_VX;
                end

                // friction: |v| then -v*coeff/|v|
                S_FR_M1: r_state <= S_FR_M2;
                S_FR_M2: begin
                    r_sum   <= r_prod[63:0];
                    r_state <= S_FR_M3;
                end
                S_FR_M3: begin
                    r_rad   <= r_sum + r_prod[63:0];
                    r_root  <= '0;
                    r_srem  <= '0;
                    r_cnt   <= pes2d_pkg::SQRT_STEPS;
                    r_ret   <= S_FR_NX;
                    r_state <= S_SQRT;
                end
                S_FR_NX: begin
                    if (r_root == 32'd0) begin
                        r_fx    <= '0;
                        r_fy    <= '0;
                        r_state <= S_FD_X;
                    end else begin
                        r_state <= S_FR_DX;
                    end
                end
                S_FR_DX, S_FR_DY, S_SP_DX, S_SP_DY, S_FD_X, S_FD_Y: begin
                    r_dvd   <= w_dabs;
                    r_neg   <= w_dnum[63];
                    r_dvs   <= w_dden;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= pes2d_pkg::DIV_STEPS;
                    r_state <= S_DIV;
                    case (r_state)
                        S_FR_DX: r_ret <= S_FR_NY;
                        S_FR_DY: r_ret <= S_FR_FY;
                        S_SP_DX: r_ret <= S_SP_NY;
                        S_SP_DY: r_ret <= S_SP_TY;
                        S_FD_X:  r_ret <= S_FD_AX;
                        default: r_ret <= S_FD_AY;
                    endcase
                end
                S_FR_NY: begin
                    r_fx    <= 64'(pes2d_pkg::f_sat32({{2{w_quo[63]}}, w_quo}));
                    r_state <= S_FR_DY;
                end
                S_FR_FY: begin
                    r_fy    <= 64'(pes2d_pkg::f_sat32({{2{w_quo[63]}}, w_quo}));
                    r_state <= S_FD_X;
                end

                // spring: offset, distance, stiffness, direction, damping
                S_SP_D: begin
                    r_dx <= pes2d_pkg::f_sat32($signed({{34{r_pos_x[31]}}, r_pos_x}) -
                                               $signed({{34{r_ax[31]}}, r_ax}));
                    r_dy <= pes2d_pkg::f_sat32($signed({{34{r_pos_y[31]}}, r_pos_y}) -
                                               $signed({{34{r_ay[31]}}, r_ay}));
                    r_state <= S_SP_M1;
                end
                S_SP_M1: r_state <= S_SP_M2;
                S_SP_M2: begin
                    r_sum   <= r_prod[63:0];
                    r_state <= S_SP_M3;
                end
                S_SP_M3: begin
                    r_rad   <= r_sum + r_prod[63:0];
                    r_root  <= '0;
                    r_srem  <= '0;
                    r_cnt   <= pes2d_pkg::SQRT_STEPS;
                    r_ret   <= S_SP_K;
                    r_state <= S_SQRT;
                end
                S_SP_K: r_state <= S_SP_KX;
                S_SP_KX: begin
                    r_kx <= w_mulq;
                    if (r_root == 32'd0) begin
                        r_fx    <= '0;
                        r_fy    <= '0;
                        r_state <= S_SP_DAMP;
                    end else begin
                        r_state <= S_SP_NX;
                    end
                end
                S_SP_NX: r_state <= S_SP_DX;
                S_SP_NY: begin
                    r_fx    <= w_quo;
                    r_state <= S_SP_DY;
                end
                S_SP_TY: begin
                    r_fy    <= w_quo;
                    r_state <= S_SP_DAMP;
                end
                S_SP_DAMP: begin
                    r_fx <= 64'(pes2d_pkg::f_sat32($signed({{2{r_fx[63]}}, r_fx}) -
                                                   $signed({{32{w_dmp_x[33]}}, w_dmp_x})));
                    r_fy <= 64'(pes2d_pkg::f_sat32($signed({{2{r_fy[63]}}, r_fy}) -
                                                   $signed({{32{w_dmp_y[33]}}, w_dmp_y})));
                    r_state <= S_FD_X;
                end

                // force / mass into acceleration
                S_FD_AX: begin
                    r_acc_x <= pes2d_pkg::f_add_sat(r_acc_x,
                                   pes2d_pkg::f_sat32({{2{w_quo[63]}}, w_quo}));
                    r_state <= S_FD_Y;
                end
                S_FD_AY: begin
                    r_acc_y <= pes2d_pkg::f_add_sat(r_acc_y,
                                   pes2d_pkg::f_sat32({{2{w_quo[63]}}, w_quo}));
                    r_state <= (r_kind == pes2d_pkg::KIND_TICK) ? S_VX : S_IDLE;
                end

                // integrate velocity then position
                S_VX: r_state <= S_VX2;
                S_VX2: begin
                    r_vel_x <= w_vcl;
                    r_state <= S_VY2;
                end
                S_VY2: begin
                    r_vel_y <= w_vcl;
                    r_state <= S_PX;
                end
                S_PX: r_state <= S_PX2;
                S_PX2: begin
                    r_pos_x <= pes2d_pkg::f_add_sat(r_pos_x, w_mulq);
                    r_state <= S_PY2;
                end
                S_PY2: begin
                    r_pos_y <= pes2d_pkg::f_add_sat(r_pos_y, w_mulq);
                    r_acc_x <= '0;
                    r_acc_y <= '0;
                    r_state <= S_WR;
                end

                // walls: right, left, top, bottom
                S_WR: r_state <= S_WR2;
                S_WR2: begin
                    if (w_hit_r) begin
                        r_vel_x <= w_nvx[31:0];
                        r_pos_x <= pes2d_pkg::BOX_W_Q - pes2d_pkg::WALL_OFFSET -
                                   {13'b0, r_radius};
                    end
                    r_state <= S_WL;
                end
                S_WL: r_state <= S_WL2;
                S_WL2: begin
                    if (w_hit_l) begin
                        r_vel_x <= w_nvx[31:0];
                        r_pos_x <= {13'b0, r_radius} + pes2d_pkg::WALL_OFFSET;
                    end
                    r_state <= S_WT;
                end
                S_WT: r_state <= S_WT2;
                S_WT2: begin
                    if (w_hit_t) begin
                        r_vel_y <= w_nvy[31:0];
                        r_pos_y <= pes2d_pkg::BOX_H_Q - pes2d_pkg::WALL_OFFSET -
                                   {13'b0, r_radius};
                    end
                    r_state <= S_WB;
                end
                S_WB: r_state <= S_WB2;
                S_WB2: begin
                    if (w_hit_b) begin
                        r_vel_y <= w_nvy[31:0];
                        r_pos_y <= {13'b0, r_radius} + pes2d_pkg::WALL_OFFSET;
                    end
                    r_state <= S_OUT;
                end

                // hand the new position to the output register
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out_x  <= r_pos_x;
                        r_out_y  <= r_pos_y;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `PES2D_ASSERT_NOW(a_div_cnt,
        (r_state == S_DIV) || (r_state == S_SQRT), r_cnt != 7'd0,
        "iteration counter ran out")
    `PES2D_ASSERT_NEXT(a_out_load,
        (r_state == S_OUT) && (!r_ovalid || !i_out_stall),
        r_ovalid && (r_state == S_IDLE), "result word not loaded")
    `PES2D_ASSERT_NEXT(a_force_path,
        i_in_valid && !o_in_stall && (i_kind == pes2d_pkg::KIND_FORCE),
        r_state == S_FD_X, "force word not sent to mass divide")
    `PES2D_ASSERT_NOW(a_acc_clear,
        r_state == S_WR, (r_acc_x == 32'sd0) && (r_acc_y == 32'sd0),
        "acceleration not cleared before walls")

endmodule
